### rtl/bda_pkg.sv
// Shared types, constants, note tables and microcode program for the note dispenser.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  // Field and register widths
  localparam int KINDS   = 6;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 10;
  localparam int AMT_W   = 23;
  localparam int Q_W     = 17;
  localparam int REST_W  = 16;
  localparam int USED_W  = 11;
  localparam int FACE_W  = 13;
  localparam int UNIT_W  = 6;
  localparam int RECIP_W = 24;
  localparam int PROD_W  = AMT_W + RECIP_W;
  localparam int PC_W    = 5;
  localparam int OP_W    = 3;

  // Reciprocal shifts: amount / 100 uses 2^30, the per-note quotients in units of 100 use 2^22
  localparam int SH_AMT  = 30;
  localparam int SH_UNIT = 22;

  localparam logic [CNT_W-1:0]   CAPACITY   = 10'd1000;
  localparam logic [AMT_W-1:0]   MIN_AMOUNT = 23'd100;
  localparam logic [6:0]         HUNDRED    = 7'd100;
  localparam logic [RECIP_W-1:0] RECIP_100  = 24'd10737419;

  // Note kinds
  localparam logic [KIND_W-1:0] KIND_100  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_200  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_500  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_1000 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_2000 = 3'd4;
  localparam logic [KIND_W-1:0] KIND_5000 = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOCOMP  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Command codes
  localparam logic CMD_WITHDRAW = 1'b0;
  localparam logic CMD_DEPOSIT  = 1'b1;

  // Datapath operations of one microcode step
  localparam logic [OP_W-1:0] OP_DISP   = 3'd0;  // clear result, branch on command
  localparam logic [OP_W-1:0] OP_QAMT   = 3'd1;  // q = amount / 100
  localparam logic [OP_W-1:0] OP_CHKAMT = 3'd2;  // check amount, branch out if bad
  localparam logic [OP_W-1:0] OP_QREST  = 3'd3;  // q = rest / unit(kind)
  localparam logic [OP_W-1:0] OP_TAKE   = 3'd4;  // take min(q, stock), reduce rest
  localparam logic [OP_W-1:0] OP_COMMIT = 3'd5;  // apply or drop the withdrawal
  localparam logic [OP_W-1:0] OP_DEP    = 3'd6;  // one-note deposit
  localparam logic [OP_W-1:0] OP_END    = 3'd7;  // hand result to output register

  // Program addresses that are jump targets
  localparam logic [PC_W-1:0] ADDR_DEP = 5'd16;
  localparam logic [PC_W-1:0] ADDR_END = 5'd17;

  typedef struct packed {
    logic              cmd;
    logic [AMT_W-1:0]  amount;
    logic [KIND_W-1:0] note_kind;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] out_100;
    logic [CNT_W-1:0] out_200;
    logic [CNT_W-1:0] out_500;
    logic [CNT_W-1:0] out_1000;
    logic [CNT_W-1:0] out_2000;
    logic [CNT_W-1:0] out_5000;
    logic [CNT_W-1:0] notes_left;
    logic [AMT_W-1:0] value_left;
  } rsp_t;

  // One control word of the program
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] kind;
    logic [PC_W-1:0]   target;
  } uword_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic              en;
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] kind;
  } ctl_t;

  // Face value of a note
  function automatic logic [FACE_W-1:0] face_value(input logic [KIND_W-1:0] kind);
    logic [FACE_W-1:0] f;
    unique case (kind)
      KIND_100:  f = 13'd100;
      KIND_200:  f = 13'd200;
      KIND_500:  f = 13'd500;
      KIND_1000: f = 13'd1000;
      KIND_2000: f = 13'd2000;
      KIND_5000: f = 13'd5000;
      default:   f = '0;
    endcase
    return f;
  endfunction

  // Face value in units of 100
  function automatic logic [UNIT_W-1:0] note_unit(input logic [KIND_W-1:0] kind);
    logic [UNIT_W-1:0] u;
    unique case (kind)
      KIND_100:  u = 6'd1;
      KIND_200:  u = 6'd2;
      KIND_500:  u = 6'd5;
      KIND_1000: u = 6'd10;
      KIND_2000: u = 6'd20;
      KIND_5000: u = 6'd50;
      default:   u = '0;
    endcase
    return u;
  endfunction

  // ceil(2^22 / unit): exact quotient for dividends below 2^16
  function automatic logic [RECIP_W-1:0] recip_unit(input logic [KIND_W-1:0] kind);
    logic [RECIP_W-1:0] m;
    unique case (kind)
      KIND_100:  m = 24'd4194304;
      KIND_200:  m = 24'd2097152;
      KIND_500:  m = 24'd838861;
      KIND_1000: m = 24'd419431;
      KIND_2000: m = 24'd209716;
      KIND_5000: m = 24'd83887;
      default:   m = '0;
    endcase
    return m;
  endfunction

  // Microcode program: withdraw at 1..15, deposit at ADDR_DEP, both end at ADDR_END
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w.op     = OP_END;
    w.kind   = KIND_100;
    w.target = ADDR_END;
    unique case (pc)
      5'd0:  begin w.op = OP_DISP;   w.target = ADDR_DEP; end
      5'd1:  w.op = OP_QAMT;
      5'd2:  w.op = OP_CHKAMT;
      5'd3:  begin w.op = OP_QREST;  w.kind = KIND_5000; end
      5'd4:  begin w.op = OP_TAKE;   w.kind = KIND_5000; end
      5'd5:  begin w.op = OP_QREST;  w.kind = KIND_2000; end
      5'd6:  begin w.op = OP_TAKE;   w.kind = KIND_2000; end
      5'd7:  begin w.op = OP_QREST;  w.kind = KIND_1000; end
      5'd8:  begin w.op = OP_TAKE;   w.kind = KIND_1000; end
      5'd9:  begin w.op = OP_QREST;  w.kind = KIND_500; end
      5'd10: begin w.op = OP_TAKE;   w.kind = KIND_500; end
      5'd11: begin w.op = OP_QREST;  w.kind = KIND_200; end
      5'd12: begin w.op = OP_TAKE;   w.kind = KIND_200; end
      5'd13: begin w.op = OP_QREST;  w.kind = KIND_100; end
      5'd14: begin w.op = OP_TAKE;   w.kind = KIND_100; end
      5'd15: w.op = OP_COMMIT;
      5'd16: w.op = OP_DEP;
      default: w.op = OP_END;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/banknote_dispense_allocator.sv
// Top level of the note dispenser: request capture, sequencer, datapath, result register.
//
// Requests enter on req (valid/stall): a withdraw of an amount, or a one-note deposit.
// One result word per request leaves on rsp (valid/stall) with the status, the notes
// given per kind, and the note total and stored value after the request.
// A request is taken when req_valid is high and req_stall low; req_stall stays high
// while the microcode sequencer works on a request, one program step per cycle.
// A withdraw runs the full greedy pass (a reciprocal multiply and a take step per note
// kind, largest first) and a commit step, a rejected amount stops after the check step,
// a deposit runs one step; the next request is taken in the cycle after the handoff.
// The program's last step waits while the result register is full and stalled; a
// result waiting in that register does not block the next request from being taken.
// Reset empties the stock (all counts, total and value zero) and leaves the block
// idle with no result pending; a stalled result word holds until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module banknote_dispense_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bda_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bda_pkg::rsp_t      rsp
);
  import bda_pkg::*;

  req_t  req_q;
  rsp_t  result;
  ctl_t  ctl;
  logic  busy;
  logic  start;
  logic  emit;
  logic  jump;
  logic  out_free;

  assign req_stall = busy;
  assign start     = req_valid && !busy;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Request capture
  always_ff @(posedge clk) begin
    if (start) req_q <= req;
  end

  bda_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .jump     (jump),
    .out_free (out_free),
    .ctl      (ctl),
    .busy     (busy),
    .emit     (emit)
  );

  bda_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req_q),
    .jump   (jump),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rsp <= result;
  end

endmodule

`default_nettype wire

### rtl/bda_sequencer.sv
// Microcode sequencer: step counter, program lookup and jumps.
`timescale 1ns / 1ps
`default_nettype none

module bda_sequencer (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    jump,
  input  wire logic    out_free,
  output bda_pkg::ctl_t ctl,
  output logic         busy,
  output logic         emit
);
  import bda_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;
  uword_t          uw;

  assign uw = ucode(pc);

  // Control word to the datapath
  always_comb begin
    ctl.en   = busy;
    ctl.op   = uw.op;
    ctl.kind = uw.kind;
  end

  // Final step hands off once the output register can take the word
  assign emit = busy && (uw.op == OP_END) && out_free;

  // Next step
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      busy_next = 1'b1;
      pc_next   = '0;
    end else if (busy) begin
      if (uw.op == OP_END) begin
        if (out_free) busy_next = 1'b0;
      end else begin
        pc_next = jump ? uw.target : pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= ADDR_END)
    else $error("step counter left the program");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("request started while sequencer busy");

  a_emit_ends_run: assert property (@(posedge clk) disable iff (rst)
    emit |=> !busy)
    else $error("sequencer still busy after result handoff");
`endif

endmodule

`default_nettype wire

### rtl/bda_datapath.sv
// Datapath: note stock, reciprocal divider, greedy take and commit logic.
`timescale 1ns / 1ps
`default_nettype none

module bda_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bda_pkg::ctl_t  ctl,
  input  wire bda_pkg::req_t  req,
  output logic                jump,
  output bda_pkg::rsp_t       result
);
  import bda_pkg::*;

  // Stored state
  logic [CNT_W-1:0]  stock [KINDS];
  logic [CNT_W-1:0]  total;
  logic [AMT_W-1:0]  value;

  // Working registers
  logic [Q_W-1:0]    q;
  logic [REST_W-1:0] rest;
  logic [CNT_W-1:0]  given [KINDS];
  logic [USED_W-1:0] used;
  logic [1:0]        status;

  logic [AMT_W-1:0]   mul_x;
  logic [RECIP_W-1:0] mul_m;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q_prod;
  logic [AMT_W:0]     amt_x100;
  logic               amt_bad;
  logic [KIND_W-1:0]  sel_kind;
  logic [CNT_W-1:0]   stock_sel;
  logic [CNT_W-1:0]   take;
  logic [REST_W-1:0]  take_val;
  logic               dep_ok;

  // Reciprocal multiply: amount / 100 or rest / unit
  always_comb begin
    if (ctl.op == OP_QAMT) begin
      mul_x = req.amount;
      mul_m = RECIP_100;
    end else begin
      mul_x = {{(AMT_W-REST_W){1'b0}}, rest};
      mul_m = recip_unit(ctl.kind);
    end
  end

  assign prod   = {{RECIP_W{1'b0}}, mul_x} * {{AMT_W{1'b0}}, mul_m};
  assign q_prod = (ctl.op == OP_QAMT) ? prod[SH_AMT +: Q_W] : prod[SH_UNIT +: Q_W];

  // Amount check: multiple of 100, at least 100, covered by stored value
  assign amt_x100 = {{(AMT_W+1-Q_W){1'b0}}, q} * {{(AMT_W+1-7){1'b0}}, HUNDRED};
  assign amt_bad  = (amt_x100 != {1'b0, req.amount}) || (req.amount < MIN_AMOUNT) ||
                    (req.amount > value);

  // Stock read port for the take and deposit steps
  assign sel_kind  = (ctl.op == OP_DEP) ? req.note_kind : ctl.kind;
  assign stock_sel = stock[sel_kind];

  // Greedy take for one note kind
  assign take     = (q > {{(Q_W-CNT_W){1'b0}}, stock_sel}) ? stock_sel : q[CNT_W-1:0];
  assign take_val = {{UNIT_W{1'b0}}, take} * {{CNT_W{1'b0}}, note_unit(ctl.kind)};

  assign dep_ok = (total < CAPACITY) && (req.note_kind <= KIND_5000);

  // Branch condition of the current step
  always_comb begin
    unique case (ctl.op)
      OP_DISP:   jump = (req.cmd == CMD_DEPOSIT);
      OP_CHKAMT: jump = amt_bad;
      OP_COMMIT: jump = 1'b1;
      OP_DEP:    jump = 1'b1;
      default:   jump = 1'b0;
    endcase
  end

  // Stock, note total and stored value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KINDS; k++) stock[k] <= '0;
      total <= '0;
      value <= '0;
    end else if (ctl.en) begin
      if (ctl.op == OP_COMMIT && rest == '0) begin
        for (int k = 0; k < KINDS; k++) stock[k] <= stock[k] - given[k];
        total <= ({1'b0, total} >= used) ? total - used[CNT_W-1:0] : '0;
        value <= value - req.amount;
      end else if (ctl.op == OP_DEP && dep_ok) begin
        stock[sel_kind] <= stock_sel + 1'b1;
        total           <= total + 1'b1;
        value           <= value + {{(AMT_W-FACE_W){1'b0}}, face_value(sel_kind)};
      end
    end
  end

  // Working registers for one request
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      unique case (ctl.op)
        OP_DISP: begin
          for (int k = 0; k < KINDS; k++) given[k] <= '0;
          used   <= '0;
          status <= ST_OK;
        end
        OP_QAMT:  q <= q_prod;
        OP_QREST: q <= q_prod;
        OP_CHKAMT: begin
          if (amt_bad) status <= ST_INVALID;
          else rest <= q[REST_W-1:0];
        end
        OP_TAKE: begin
          given[ctl.kind] <= take;
          rest            <= rest - take_val;
          used            <= used + {1'b0, take};
        end
        OP_COMMIT: begin
          if (rest != '0) begin
            status <= ST_NOCOMP;
            for (int k = 0; k < KINDS; k++) given[k] <= '0;
          end
        end
        OP_DEP: begin
          if (total >= CAPACITY) status <= ST_FULL;
          else if (req.note_kind > KIND_5000) status <= ST_INVALID;
        end
        OP_END: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result word
  always_comb begin
    result.status     = status;
    result.out_100    = given[KIND_100];
    result.out_200    = given[KIND_200];
    result.out_500    = given[KIND_500];
    result.out_1000   = given[KIND_1000];
    result.out_2000   = given[KIND_2000];
    result.out_5000   = given[KIND_5000];
    result.notes_left = total;
    result.value_left = value;
  end

`ifndef SYNTHESIS
  a_total_capped: assert property (@(posedge clk) disable iff (rst)
    total <= CAPACITY)
    else $error("note total above capacity");

  a_used_in_stock: assert property (@(posedge clk) disable iff (rst)
    (ctl.en && ctl.op == OP_COMMIT) |-> used <= {1'b0, total})
    else $error("greedy pass took more notes than stored");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    (ctl.en && ctl.op == OP_COMMIT && rest == '0) |=> status == ST_OK)
    else $error("covered withdrawal not reported ok");
`endif

endmodule

`default_nettype wire

### tb/sv/banknote_dispense_allocator_tb.sv
// Self-checking testbench for the banknote dispense allocator: directed and random requests.
`timescale 1ns / 1ps

module banknote_dispense_allocator_tb;
  import bda_pkg::*;

  localparam int          LONG_HOLD  = 80;
  localparam int          END_CYCLES = 24;
  localparam longint      TIMEOUT_NS = 1_000_000;
  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Predicted stock, kept in step with accepted requests
  logic [CNT_W-1:0] stock_q [KINDS];
  logic [CNT_W-1:0] notes_q = '0;
  rsp_t             outcome_q [$];

  int errors     = 0;
  int words_seen = 0;
  bit idle_on    = 1'b1;
  bit hold_start = 1'b0;
  int hold_cnt   = 0;
  int burst_cnt  = 0;
  int calm_cnt   = 0;

  banknote_dispense_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < KINDS; k++) stock_q[k] = '0;
  end

  // Face value of a note kind
  function automatic int unsigned note_face(input int k);
    case (k)
      KIND_100:  note_face = 100;
      KIND_200:  note_face = 200;
      KIND_500:  note_face = 500;
      KIND_1000: note_face = 1000;
      KIND_2000: note_face = 2000;
      default:   note_face = 5000;
    endcase
  endfunction

  function automatic int unsigned stock_value();
    int unsigned v;
    int k;
    v = 0;
    for (k = 0; k < KINDS; k++) v += note_face(k) * stock_q[k];
    return v;
  endfunction

  // Expected result word for one request; updates the predicted stock
  function automatic rsp_t dispense_outcome(input req_t r);
    rsp_t o;
    int unsigned given [KINDS];
    int unsigned rest, take, used;
    int k;
    o = '0;
    for (k = 0; k < KINDS; k++) given[k] = 0;
    if (r.cmd == CMD_DEPOSIT) begin
      // full check wins over a bad note kind
      if (notes_q >= CAPACITY) begin
        o.status = ST_FULL;
      end else if (r.note_kind >= KINDS) begin
        o.status = ST_INVALID;
      end else begin
        stock_q[r.note_kind] = stock_q[r.note_kind] + 1'b1;
        notes_q = notes_q + 1'b1;
        o.status = ST_OK;
      end
    end else if ((r.amount % 100) != 0 || r.amount < MIN_AMOUNT ||
                 r.amount > stock_value()) begin
      o.status = ST_INVALID;
    end else begin
      // greedy pass, largest note first, bounded by stock
      rest = r.amount;
      used = 0;
      for (k = KINDS - 1; k >= 0; k--) begin
        take = rest / note_face(k);
        if (take > stock_q[k]) take = stock_q[k];
        given[k] = take;
        rest -= take * note_face(k);
        used += take;
      end
      if (rest != 0) begin
        o.status = ST_NOCOMP;
        for (k = 0; k < KINDS; k++) given[k] = 0;
      end else begin
        for (k = 0; k < KINDS; k++) stock_q[k] = stock_q[k] - CNT_W'(given[k]);
        notes_q = (notes_q >= used) ? notes_q - CNT_W'(used) : '0;
        o.status = ST_OK;
      end
    end
    o.out_100    = CNT_W'(given[0]);
    o.out_200    = CNT_W'(given[1]);
    o.out_500    = CNT_W'(given[2]);
    o.out_1000   = CNT_W'(given[3]);
    o.out_2000   = CNT_W'(given[4]);
    o.out_5000   = CNT_W'(given[5]);
    o.notes_left = notes_q;
    o.value_left = AMT_W'(stock_value());
    return o;
  endfunction

  function automatic req_t withdraw_req(input logic [AMT_W-1:0] amt);
    req_t r;
    r.cmd       = CMD_WITHDRAW;
    r.amount    = amt;
    r.note_kind = KIND_W'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic req_t deposit_req(input logic [KIND_W-1:0] kind);
    req_t r;
    r.cmd       = CMD_DEPOSIT;
    r.amount    = AMT_W'($urandom);
    r.note_kind = kind;
    return r;
  endfunction

  // Mostly sums the stock can cover, sometimes the whole store or just past it
  function automatic logic [AMT_W-1:0] reachable_amount();
    int unsigned sum, lim;
    int k, pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return AMT_W'(stock_value());
    if (pick == 1) return AMT_W'(stock_value() + 100);
    sum = 0;
    for (k = 0; k < KINDS; k++) begin
      lim = (stock_q[k] < 3) ? stock_q[k] : 3;
      sum += note_face(k) * $urandom_range(0, lim);
    end
    return (sum == 0) ? MIN_AMOUNT : AMT_W'(sum);
  endfunction

  function automatic req_t mixed_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return deposit_req(KIND_W'($urandom_range(0, KINDS - 1)));
    if (pick < 40) return deposit_req(KIND_W'($urandom_range(0, 7)));
    if (pick < 80) return withdraw_req(reachable_amount());
    if (pick < 90) return withdraw_req(AMT_W'(100 * $urandom_range(1, stock_value() / 100 + 2)));
    if (pick < 95) return withdraw_req(AMT_W'($urandom));
    return withdraw_req(reachable_amount() + AMT_W'($urandom_range(1, 99)));
  endfunction

  // Offer one request word and wait for the handshake; valid stays high afterwards
  task automatic send_req(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    outcome_q.push_back(dispense_outcome(r));
  endtask

  // Drop valid and wait for every expected word
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input logic [AMT_W-1:0] got,
                                 input logic [AMT_W-1:0] want);
    $display("word %0d: %s got %0d expected %0d", words_seen, what, got, want);
    errors++;
  endtask

  // Result checker
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected word, status", rsp.status, '0);
      end else begin
        want = outcome_q.pop_front();
        if (rsp.status !== want.status)         report_mismatch("status", rsp.status, want.status);
        if (rsp.out_100 !== want.out_100)       report_mismatch("out_100", rsp.out_100, want.out_100);
        if (rsp.out_200 !== want.out_200)       report_mismatch("out_200", rsp.out_200, want.out_200);
        if (rsp.out_500 !== want.out_500)       report_mismatch("out_500", rsp.out_500, want.out_500);
        if (rsp.out_1000 !== want.out_1000)     report_mismatch("out_1000", rsp.out_1000, want.out_1000);
        if (rsp.out_2000 !== want.out_2000)     report_mismatch("out_2000", rsp.out_2000, want.out_2000);
        if (rsp.out_5000 !== want.out_5000)     report_mismatch("out_5000", rsp.out_5000, want.out_5000);
        if (rsp.notes_left !== want.notes_left) begin
          report_mismatch("notes_left", rsp.notes_left, want.notes_left);
        end
        if (rsp.value_left !== want.value_left) begin
          report_mismatch("value_left", rsp.value_left, want.value_left);
        end
      end
      words_seen++;
    end
  end

  // Receiver pacing: long hold on request, short bursts, calm stretches
  always @(posedge clk) begin : rsp_pacing
    if (hold_start) begin
      hold_cnt   = LONG_HOLD;
      hold_start = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_stall <= 1'b1;
    end else if (burst_cnt > 0) begin
      burst_cnt--;
      rsp_stall <= 1'b1;
      if (burst_cnt == 0 && $urandom_range(0, 3) == 0) calm_cnt = $urandom_range(10, 40);
    end else if (calm_cnt > 0) begin
      calm_cnt--;
      rsp_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_cnt = $urandom_range(0, 4);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Requests against an empty store, plus bad note kinds
  task automatic test_empty_store();
    send_req(withdraw_req(MIN_AMOUNT));
    send_req(withdraw_req('0));
    send_req(withdraw_req('1));
    send_req(deposit_req(KIND_BAD_LO));
    send_req(deposit_req(KIND_BAD_HI));
    settle();
  endtask

  // One note of each kind, then malformed and exact withdrawals
  task automatic test_each_note();
    send_req(deposit_req(KIND_100));
    send_req(deposit_req(KIND_200));
    send_req(deposit_req(KIND_500));
    send_req(deposit_req(KIND_1000));
    send_req(deposit_req(KIND_2000));
    send_req(deposit_req(KIND_5000));
    send_req(withdraw_req(23'd150));
    send_req(withdraw_req(23'd99));
    send_req(withdraw_req(23'd8900));
    send_req(withdraw_req(23'd8800));
    settle();
  endtask

  // 600 from one 500 and three 200: greedy takes the 500 and misses
  task automatic test_greedy_miss();
    send_req(deposit_req(KIND_500));
    send_req(deposit_req(KIND_200));
    send_req(deposit_req(KIND_200));
    send_req(deposit_req(KIND_200));
    send_req(withdraw_req(23'd600));
    send_req(withdraw_req(23'd1100));
    send_req(withdraw_req(23'd5000000));
    settle();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_req(mixed_req());
    settle();
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_start = 1'b1;
    repeat (8) send_req(mixed_req());
    settle();
  endtask

  // Deposit up to capacity, then hit the full store
  task automatic test_fill_store();
    int guard;
    for (guard = 0; guard < 4000 && notes_q < CAPACITY; guard++) begin
      if ($urandom_range(0, 49) == 0) send_req(withdraw_req(AMT_W'($urandom)));
      else send_req(deposit_req(KIND_W'($urandom_range(0, KINDS - 1))));
    end
    repeat (12) send_req(deposit_req(KIND_W'($urandom_range(0, 7))));
    send_req(withdraw_req(AMT_W'(stock_value())));
    repeat (6) send_req(deposit_req(KIND_W'($urandom_range(0, 7))));
    settle();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_flow(input int count);
    idle_on = 1'b0;
    repeat (count) send_req(mixed_req());
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_each_note();
    test_greedy_miss();
    test_random_mix(40);
    test_backpressure();
    test_fill_store();
    test_random_mix(30);
    test_steady_flow(30);
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d words outstanding", outcome_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
rtl/bda_pkg.sv
rtl/bda_sequencer.sv
rtl/bda_datapath.sv
rtl/banknote_dispense_allocator.sv
tb/sv/banknote_dispense_allocator_tb.sv
